[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define PSEA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset
`define PSEA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/psea_pkg.sv]
// Shared types and constants for the pad sampler
`timescale 1ns / 1ps

package psea_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned BTN_W    = 28;
    localparam int unsigned BCNT_W   = 5;
    localparam int unsigned HOLD_W   = 17;
    localparam int unsigned PHASE_W  = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned DIR_BITS = 4;

    localparam logic [BCNT_W-1:0] BTN_LIMIT = BCNT_W'(BTN_W);
    localparam logic [HOLD_W-1:0] HOLD_MAX  = {HOLD_W{1'b1}};

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [IDX_W-1:0] {
        REG_X_LOW    = 3'd0,
        REG_X_HIGH   = 3'd1,
        REG_Y_LOW    = 3'd2,
        REG_Y_HIGH   = 3'd3,
        REG_DELAY    = 3'd4,
        REG_PERIOD   = 3'd5,
        REG_BTN_CNT  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [POS_W-1:0]   x_low;
        logic [POS_W-1:0]   x_high;
        logic [POS_W-1:0]   y_low;
        logic [POS_W-1:0]   y_high;
        logic [CFG_W-1:0]   delay;
        logic [CFG_W-1:0]   period;
        logic [BCNT_W-1:0]  btn_cnt;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] stick_x;
        logic [POS_W-1:0] stick_y;
        logic [BTN_W-1:0] button_bits;
        logic             sample_ok;
    } t_sample;

    typedef struct packed {
        t_word repeat_word;
        t_word released_word;
        t_word pressed_word;
        t_word held_word;
    } t_result;

endpackage

[rtl/psea_cfg_regs.sv]
// Configuration register file for the pad sampler
`timescale 1ns / 1ps

module psea_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [psea_pkg::IDX_W-1:0]      i_cfg_addr,
    input  logic [psea_pkg::CFG_W-1:0]      i_cfg_wdata,
    output psea_pkg::t_cfg                  o_cfg
);

    psea_pkg::t_cfg r_cfg;
    psea_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (psea_pkg::t_reg_idx'(i_cfg_addr))
                psea_pkg::REG_X_LOW:   n_cfg.x_low   = i_cfg_wdata;
                psea_pkg::REG_X_HIGH:  n_cfg.x_high  = i_cfg_wdata;
                psea_pkg::REG_Y_LOW:   n_cfg.y_low   = i_cfg_wdata;
                psea_pkg::REG_Y_HIGH:  n_cfg.y_high  = i_cfg_wdata;
                psea_pkg::REG_DELAY:   n_cfg.delay   = i_cfg_wdata;
                psea_pkg::REG_PERIOD:  n_cfg.period  = i_cfg_wdata;
                psea_pkg::REG_BTN_CNT: n_cfg.btn_cnt = i_cfg_wdata[psea_pkg::BCNT_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_low   <= 16'd21845;
            r_cfg.x_high  <= 16'd43690;
            r_cfg.y_low   <= 16'd21845;
            r_cfg.y_high  <= 16'd43690;
            r_cfg.delay   <= 16'd20;
            r_cfg.period  <= 16'd4;
            r_cfg.btn_cnt <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/psea_quant.sv]
// Stick quantiser and button mask: forms the pad word of one sample
`timescale 1ns / 1ps

module psea_quant (
    input  psea_pkg::t_cfg      i_cfg,
    input  psea_pkg::t_sample   i_sample,
    output psea_pkg::t_word     o_word
);

    logic [psea_pkg::BCNT_W-1:0]   btn_n;
    logic [psea_pkg::BTN_W-1:0]    btn_mask;
    logic [psea_pkg::DIR_BITS-1:0] dir;

    assign btn_n = (i_cfg.btn_cnt > psea_pkg::BTN_LIMIT) ? psea_pkg::BTN_LIMIT : i_cfg.btn_cnt;

    always_comb begin
        for (int i = 0; i < psea_pkg::BTN_W; i++) begin
            btn_mask[i] = (psea_pkg::BCNT_W'(i) < btn_n);
        end
    end

    // Low limit wins on each axis: up over down, left over right
    always_comb begin
        dir = '0;
        if (i_sample.stick_y <= i_cfg.y_low) begin
            dir[0] = 1'b1;
        end else if (i_sample.stick_y >= i_cfg.y_high) begin
            dir[1] = 1'b1;
        end
        if (i_sample.stick_x <= i_cfg.x_low) begin
            dir[2] = 1'b1;
        end else if (i_sample.stick_x >= i_cfg.x_high) begin
            dir[3] = 1'b1;
        end
    end

    assign o_word = i_sample.sample_ok ? {i_sample.button_bits & btn_mask, dir} : '0;

endmodule

[rtl/psea_track.sv]
// Edge detection and auto-repeat timing on the pad word
`timescale 1ns / 1ps

module psea_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psea_pkg::t_cfg      i_cfg,
    input  logic                i_advance,
    input  psea_pkg::t_word     i_word,
    output psea_pkg::t_result   o_result
);

    psea_pkg::t_word                   r_last_word;
    logic [psea_pkg::HOLD_W-1:0]       r_hold_ticks;
    logic [psea_pkg::PHASE_W-1:0]      r_repeat_phase;

    psea_pkg::t_word                   n_last_word;
    logic [psea_pkg::HOLD_W-1:0]       n_hold_ticks;
    logic [psea_pkg::PHASE_W-1:0]      n_repeat_phase;

    psea_pkg::t_word                   diff;
    logic [psea_pkg::HOLD_W-1:0]       hold_inc;
    logic [psea_pkg::PHASE_W-1:0]      phase_inc;
    logic [psea_pkg::CFG_W-1:0]        period;
    logic                              pulse;

    assign diff      = i_word ^ r_last_word;
    assign period    = (i_cfg.period == '0) ? psea_pkg::CFG_W'(1) : i_cfg.period;
    assign hold_inc  = (r_hold_ticks == psea_pkg::HOLD_MAX) ? r_hold_ticks
                                                            : r_hold_ticks + 1'b1;
    assign phase_inc = r_repeat_phase + 1'b1;

    always_comb begin
        pulse          = 1'b0;
        n_hold_ticks   = hold_inc;
        n_repeat_phase = r_repeat_phase;
        if (diff != '0) begin
            pulse          = 1'b1;
            n_hold_ticks   = '0;
            n_repeat_phase = '0;
        end else if (hold_inc > {1'b0, i_cfg.delay}) begin
            // Past the delay: advance the phase and fire when it meets the period
            if (phase_inc >= period) begin
                pulse          = 1'b1;
                n_repeat_phase = '0;
            end else begin
                n_repeat_phase = phase_inc;
            end
        end
    end

    assign n_last_word = i_word;

    assign o_result.held_word     = i_word;
    assign o_result.pressed_word  = diff & i_word;
    assign o_result.released_word = diff & r_last_word;
    assign o_result.repeat_word   = pulse ? i_word : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_word    <= '0;
            r_hold_ticks   <= '0;
            r_repeat_phase <= '0;
        end else if (i_advance) begin
            r_last_word    <= n_last_word;
            r_hold_ticks   <= n_hold_ticks;
            r_repeat_phase <= n_repeat_phase;
        end
    end

endmodule

[rtl/pad_sampler_edge_autorepeat.sv]
// Top level of the pad sampler: input register, word logic, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Pad sampler with edge detection and auto-repeat. Each input beat is one
// polling sample; it yields exactly one output beat with the held, pressed,
// released and repeat words. A beat passes the input register, then the
// result register; one sample can be taken every cycle while downstream
// takes beats: the quantiser compares and the hold/phase counters update in
// a single pass between the two registers. Configuration writes take effect
// on the next cycle and should be made only while no sample is in flight.

module pad_sampler_edge_autorepeat (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [psea_pkg::IDX_W-1:0]      i_cfg_addr,
    input  logic [psea_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [15:0] stick_x, [31:16] stick_y, [59:32] button_bits, [63:60] zero
    input  logic [63:0]                     i_s_tdata,
    // [0] sample_ok
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [31:0] held_word, [63:32] pressed_word, [95:64] released_word,
    // [127:96] repeat_word
    output logic [127:0]                    o_m_tdata
);

    psea_pkg::t_cfg      cfg;
    psea_pkg::t_sample   r_sample;
    logic                r_in_valid;
    psea_pkg::t_result   r_out;
    logic                r_out_valid;

    psea_pkg::t_word     word;
    psea_pkg::t_result   result;
    logic                out_free;
    logic                advance;
    logic                s_fire;

    logic                out_overlap;
    logic                out_chg;
    logic                out_pulse;
    logic                rpt_held;
    logic                pipe_busy;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign s_fire     = i_s_tvalid && o_s_tready;

    psea_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    psea_quant u_quant (
        .i_cfg    (cfg),
        .i_sample (r_sample),
        .o_word   (word)
    );

    psea_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_word    (word),
        .o_result  (result)
    );

    // Input register: take a beat whenever it is empty or the sample ahead moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_sample.stick_x     <= i_s_tdata[15:0];
            r_sample.stick_y     <= i_s_tdata[31:16];
            r_sample.button_bits <= i_s_tdata[59:32];
            r_sample.sample_ok   <= i_s_tuser;
        end
    end

    // Result register: hold until the downstream side takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.repeat_word, r_out.released_word,
                         r_out.pressed_word, r_out.held_word};

    assign out_overlap = (r_out.pressed_word & r_out.released_word) != '0;
    assign out_chg     = (r_out.pressed_word | r_out.released_word) != '0;
    assign out_pulse   = r_out.repeat_word != '0;
    assign rpt_held    = r_out.repeat_word == r_out.held_word;
    assign pipe_busy   = r_in_valid || r_out_valid;

    `PSEA_ASSERT(a_edges_disjoint, r_out_valid |-> !out_overlap, "pressed and released overlap")
    `PSEA_ASSERT(a_change_repeats, (r_out_valid && out_chg) |-> rpt_held, "change without repeat")
    `PSEA_ASSERT(a_repeat_is_held, (r_out_valid && out_pulse) |-> rpt_held, "repeat not held word")
    `PSEA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !pipe_busy, "pipeline busy after reset")

endmodule
